FILE: sv/bsds_pkg.sv
`default_nettype none
package bsds_pkg;

	localparam int MAX_DELIM_BYTES = 8;
	localparam int OFFSET_BITS = 32;
	localparam int LANE_W = (MAX_DELIM_BYTES > 1) ? $clog2(MAX_DELIM_BYTES) : 1;
	localparam int LEN_W = $clog2(MAX_DELIM_BYTES + 1);
	localparam logic [31:0] OFFSET_MAX = 32'((64'd1 << OFFSET_BITS) - 64'd1);
	localparam logic [30:0] PIECES_RESET = 31'h7FFF_FFFF;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] REG_DELIM_BYTES = 2'd0;
	localparam logic [1:0] REG_DELIM_LENGTH = 2'd1;
	localparam logic [1:0] REG_MAX_PIECES = 2'd2;

	typedef struct packed {
		logic        we;
		logic [1:0]  index;
		logic [63:0] data;
	} cfg_write_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_source;
	} source_t;

	typedef struct packed {
		logic [31:0] piece_offset;
		logic [31:0] piece_length;
		logic        piece_present;
		logic        last_result;
	} result_t;

endpackage
`default_nettype wire

FILE: sv/bsds_front.sv
`default_nettype none
module bsds_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  bsds_pkg::cfg_write_t cfg,
	input  wire                  accept,
	input  bsds_pkg::source_t    source,
	output logic                 res_valid,
	output bsds_pkg::result_t    result
);
	import bsds_pkg::*;

	logic [63:0]      delim_q;
	logic [3:0]       len_reg_q;
	logic [30:0]      max_q;
	logic [30:0]      pieces_left_q;
	logic [31:0]      pos_q;
	logic [31:0]      start_q;
	logic [LEN_W-1:0] bsc_q;
	logic [7:0]       win_q [MAX_DELIM_BYTES];
	logic [7:0]       win_n [MAX_DELIM_BYTES];

	logic [LEN_W-1:0] len_c;
	logic [LEN_W-1:0] bsc_inc;
	logic             hit;
	logic             cut;
	logic             last;
	logic [32:0]      p1;
	logic [32:0]      cut_at;
	logic [31:0]      p1_sat;
	logic [31:0]      cut_len;
	logic [31:0]      tail_len;

	function automatic logic [31:0] span(input logic [32:0] from, input logic [32:0] to);
		logic [32:0] d;
		d = to - from;
		if (to <= from) return 32'd0;
		return (d > {1'b0, OFFSET_MAX}) ? OFFSET_MAX : d[31:0];
	endfunction

	assign len_c = (len_reg_q > 4'(MAX_DELIM_BYTES)) ? LEN_W'(MAX_DELIM_BYTES)
		: LEN_W'(len_reg_q);
	assign bsc_inc = (bsc_q == LEN_W'(MAX_DELIM_BYTES)) ? bsc_q : bsc_q + 1'b1;

	// shift the new byte into the top lane
	always_comb begin
		for (int i = 0; i < MAX_DELIM_BYTES - 1; i++) win_n[i] = win_q[i + 1];
		win_n[MAX_DELIM_BYTES - 1] = source.data_byte;
	end

	// compare the newest len_c lanes against the delimiter
	always_comb begin
		logic [LANE_W-1:0] j;
		hit = 1'b1;
		j = '0;
		for (int k = 0; k < MAX_DELIM_BYTES; k++) begin
			if (k < int'(len_c)) begin
				j = LANE_W'(MAX_DELIM_BYTES - int'(len_c) + k);
				if (win_n[j] != delim_q[k*8 +: 8]) hit = 1'b0;
			end
		end
	end

	assign last = source.end_of_source;
	assign cut = accept && (len_c != '0) && (pieces_left_q != '0) && (bsc_inc >= len_c) && hit;
	assign p1 = {1'b0, pos_q} + 33'd1;
	assign cut_at = (p1 >= 33'(len_c)) ? p1 - 33'(len_c) : 33'd0;
	assign p1_sat = (p1 > {1'b0, OFFSET_MAX}) ? OFFSET_MAX : p1[31:0];
	assign cut_len = span({1'b0, start_q}, cut_at);
	assign tail_len = span({1'b0, start_q}, p1);

	always_comb begin
		res_valid = accept && (cut || last);
		result = '0;
		result.last_result = last;
		if (cut) begin
			result.piece_present = 1'b1;
			result.piece_offset = start_q;
			result.piece_length = cut_len;
		end else if (last && pieces_left_q != '0 && tail_len != '0) begin
			result.piece_present = 1'b1;
			result.piece_offset = start_q;
			result.piece_length = tail_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= '0;
			len_reg_q <= 4'd1;
			max_q <= PIECES_RESET;
			pieces_left_q <= PIECES_RESET;
			pos_q <= '0;
			start_q <= '0;
			bsc_q <= '0;
		end else begin
			if (cfg.we) begin
				unique case (cfg.index)
					REG_DELIM_BYTES: delim_q <= cfg.data;
					REG_DELIM_LENGTH: len_reg_q <= cfg.data[3:0];
					REG_MAX_PIECES: max_q <= cfg.data[30:0];
					default: ;
				endcase
			end
			priority if (cfg.we && cfg.index == REG_MAX_PIECES) pieces_left_q <= cfg.data[30:0];
			else if (accept && last) pieces_left_q <= max_q;
			else if (cut) pieces_left_q <= pieces_left_q - 31'd1;
			if (accept) begin
				pos_q <= last ? 32'd0 : p1_sat;
				bsc_q <= (last || cut) ? '0 : bsc_inc;
				if (last) start_q <= '0;
				else if (cut) start_q <= p1_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < MAX_DELIM_BYTES; i++) win_q[i] <= win_n[i];
		end
	end

`ifndef SYNTHESIS
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> pos_q == '0 && start_q == '0 && bsc_q == '0)
		else $error("stream state not cleared after final byte");
	a_one_piece_per_beat: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !last && !cfg.we |=>
		pieces_left_q == $past(pieces_left_q) || pieces_left_q == $past(pieces_left_q) - 31'd1)
		else $error("piece budget moved by more than one");
`endif
endmodule
`default_nettype wire

FILE: sv/bsds_queue.sv
`default_nettype none
module bsds_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                wr,
	input  bsds_pkg::result_t  wr_data,
	output logic               full,
	output logic               empty,
	input  wire                pop,
	output bsds_pkg::result_t  rd_data
);
	import bsds_pkg::*;

	result_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QPTR_W:0]   count_q;
	logic              rd;

	assign full = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign rd = pop && !empty;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr) wptr_q <= wptr_q + 1'b1;
			if (rd) rptr_q <= rptr_q + 1'b1;
			unique case ({wr, rd})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wptr_q] <= wr_data;
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_W + 1)'(QUEUE_DEPTH))
		else $error("result queue overflow");
	a_write_shows: assert property (@(posedge clk) disable iff (!arst_n)
		wr && empty |=> !empty)
		else $error("written result not visible");
`endif
endmodule
`default_nettype wire

FILE: sv/byte_stream_delimiter_splitter.sv
`default_nettype none
// Latency: a byte accepted at a clock edge shows its result (if any) with empty low
//   from the next cycle on.
// Throughput: one byte per cycle while the queue has room; the front updates window,
//   counters and budget for each byte as it is taken, so bytes stream back to back.
// Reset: arst_n clears the stream state, delimiter 0, length 1, max pieces 0x7FFFFFFF.
module byte_stream_delimiter_splitter (
	input  wire                clk,
	input  wire                arst_n,
	// source side
	input  wire                push,
	output logic               full,
	input  bsds_pkg::source_t  source,
	// result side
	output logic               empty,
	input  wire                pop,
	output bsds_pkg::result_t  result,
	// configuration writes
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire [1:0]          cfg_index,
	input  wire [63:0]         cfg_data
);
	import bsds_pkg::*;

	cfg_write_t cfg;
	logic       accept;
	logic       res_valid;
	result_t    front_result;

	// Configuration is always taken; registers live in the front.
	assign cfg_ready = 1'b1;
	assign cfg.we = cfg_valid;
	assign cfg.index = cfg_index;
	assign cfg.data = cfg_data;

	// Take a beat whenever the queue has room for a possible result.
	assign accept = push && !full;

	// Front: match the delimiter, track offsets and the piece budget.
	bsds_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.accept    (accept),
		.source    (source),
		.res_valid (res_valid),
		.result    (front_result)
	);

	// Back: hold results until the consumer pops them.
	bsds_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (res_valid),
		.wr_data (front_result),
		.full    (full),
		.empty   (empty),
		.pop     (pop),
		.rd_data (result)
	);

endmodule
`default_nettype wire

FILE: bench/bsds_checker.sv
module bsds_checker (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  wire                full,
	input  bsds_pkg::source_t  source,
	input  wire                empty,
	input  wire                pop,
	input  bsds_pkg::result_t  result,
	input  wire                cfg_valid,
	input  wire                cfg_ready,
	input  wire [1:0]          cfg_index,
	input  wire [63:0]         cfg_data,
	output int                 mismatches,
	output int                 outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import bsds_pkg::*;

	localparam logic [32:0] OFFSET_SAT = {1'b0, OFFSET_MAX};

	// register copies
	logic [63:0] delim_bytes;
	logic [3:0]  delim_len;
	logic [30:0] max_pieces;

	// stream state; offsets kept one bit wider so pos + 1 never wraps
	logic [63:0] window;
	logic [3:0]  since_cut;
	logic [32:0] position;
	logic [32:0] piece_start;
	logic [30:0] pieces_left;

	result_t expected_pieces[$];
	int      fail_count;

	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $realtime, what);
		fail_count++;
	endtask

	function automatic logic [32:0] clamp_span(input logic [32:0] from, input logic [32:0] upto);
		logic [32:0] d;
		if (upto <= from)
			return '0;
		d = upto - from;
		return (d > OFFSET_SAT) ? OFFSET_SAT : d;
	endfunction

	task automatic clear_stream();
		window = '0;
		since_cut = '0;
		position = '0;
		piece_start = '0;
		pieces_left = max_pieces;
	endtask

	// advance the splitter by one source byte and queue the result it causes
	task automatic split_byte(input source_t s);
		logic [3:0]  len;
		logic [32:0] pos, next_pos, cut_at, off, plen, tail_len;
		logic [63:0] mask, tail;
		logic        cut, present;
		result_t     r;
		len = (delim_len > 4'(MAX_DELIM_BYTES)) ? 4'(MAX_DELIM_BYTES) : delim_len;
		pos = position;
		next_pos = (pos + 33'd1 > OFFSET_SAT) ? OFFSET_SAT : pos + 33'd1;
		cut = 1'b0;
		present = 1'b0;
		off = '0;
		plen = '0;
		window = {s.data_byte, window[63:8]};
		if (since_cut < 4'd8)
			since_cut++;
		if (len != 0 && pieces_left != 0 && since_cut >= len) begin
			tail = window >> (8 * (8 - len));
			mask = (len >= 4'd8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
			if ((tail & mask) == (delim_bytes & mask)) begin
				cut_at = (pos + 33'd1 >= {29'd0, len}) ? pos + 33'd1 - {29'd0, len} : '0;
				cut = 1'b1;
				present = 1'b1;
				off = piece_start;
				plen = clamp_span(piece_start, cut_at);
				piece_start = next_pos;
				since_cut = '0;
				pieces_left--;
			end
		end
		position = next_pos;
		if (s.end_of_source) begin
			if (!cut && pieces_left != 0) begin
				tail_len = clamp_span(piece_start, pos + 33'd1);
				if (tail_len != 0) begin
					present = 1'b1;
					off = piece_start;
					plen = tail_len;
				end
			end
			clear_stream();
		end
		if (cut || s.end_of_source) begin
			r.piece_offset = off[31:0];
			r.piece_length = plen[31:0];
			r.piece_present = present;
			r.last_result = s.end_of_source;
			expected_pieces.push_back(r);
		end
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		string   diff;
		if (expected_pieces.size() == 0) begin
			report_mismatch($sformatf("unexpected result offset=%0d length=%0d present=%b last=%b",
				got.piece_offset, got.piece_length, got.piece_present, got.last_result));
			return;
		end
		want = expected_pieces.pop_front();
		diff = "";
		if (got.piece_offset !== want.piece_offset)
			diff = {diff, $sformatf(" offset got %0d want %0d", got.piece_offset, want.piece_offset)};
		if (got.piece_length !== want.piece_length)
			diff = {diff, $sformatf(" length got %0d want %0d", got.piece_length, want.piece_length)};
		if (got.piece_present !== want.piece_present)
			diff = {diff, $sformatf(" present got %b want %b", got.piece_present, want.piece_present)};
		if (got.last_result !== want.last_result)
			diff = {diff, $sformatf(" last got %b want %b", got.last_result, want.last_result)};
		if (diff != "")
			report_mismatch({"result beat:", diff});
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_bytes = '0;
			delim_len = 4'd1;
			max_pieces = PIECES_RESET;
			clear_stream();
			expected_pieces.delete();
			fail_count = 0;
			outstanding <= 0;
			mismatches <= 0;
		end else begin
			// retire first: a result popped here always belongs to an older byte
			if (!empty && pop)
				check_result(result);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DELIM_BYTES: delim_bytes = cfg_data;
					REG_DELIM_LENGTH: delim_len = cfg_data[3:0];
					REG_MAX_PIECES: begin
						max_pieces = cfg_data[30:0];
						pieces_left = cfg_data[30:0];
					end
					default: ;
				endcase
			end
			if (push && !full)
				split_byte(source);
			outstanding <= expected_pieces.size();
			mismatches <= fail_count;
		end
	end

endmodule

FILE: bench/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bsds_pkg::*;

	localparam int ITEM_TARGET = 500;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_STALL = 300;
	// results show in the cycle after the byte is taken; the rest of the wait is margin
	localparam int DRAIN_CYCLES = 4;
	// index past the last register: the block must ignore the write
	localparam logic [1:0] REG_UNUSED = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	source_t     source = '0;
	logic        pop = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [1:0]  cfg_index = REG_DELIM_BYTES;
	logic [63:0] cfg_data = '0;
	logic        full, empty, cfg_ready;
	result_t     result;
	int          mismatches, outstanding;

	int          cycles = 0;
	int          items_sent = 0;
	int          burst_left = 0;
	bit          gaps_off = 1'b0;
	// raised by the sender, dropped by the sink when its long hold-off ends
	bit          stall_request = 1'b0;
	// what the sender believes the delimiter is, to build matching sources
	logic [63:0] cur_delim = '0;
	int          cur_len = 1;

	byte_stream_delimiter_splitter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.source    (source),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bsds_checker result_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.source      (source),
		.empty       (empty),
		.pop         (pop),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// hard stop in case a handshake never completes
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Result side: pop with a duty cycle that changes every stretch, from
	// never stalling to stalling most cycles. On request, hold off for a long
	// stretch so the queue fills and the block pushes back on the source.
	initial begin : result_sink
		int stall_pct;
		int stretch;
		wait (arst_n);
		forever begin
			stretch = $urandom_range(10, 150);
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 25;
				2: stall_pct = 60;
				default: stall_pct = 90;
			endcase
			repeat (stretch) begin
				if (stall_request) begin
					pop <= 1'b0;
					repeat (LONG_STALL) @(posedge clk);
					stall_request = 1'b0;
				end
				pop <= ($urandom_range(0, 99) >= stall_pct);
				@(posedge clk);
			end
		end
	end

	// Offer one source beat and hold it until accepted. Bursts of random
	// length are separated by random gaps; a zero gap keeps push high so
	// consecutive bursts run back to back.
	task automatic offer_byte(input logic [7:0] b, input logic eos);
		int gap;
		if (burst_left == 0 && !gaps_off) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap != 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		push <= 1'b1;
		source <= {b, eos};
		@(posedge clk);
		while (full) @(posedge clk);
		items_sent++;
	endtask

	// Drop push, wait for every queued result to be popped, then let the
	// block settle. Registers may only change after this.
	task automatic pause_until_drained();
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	// Leave valid high so back-to-back writes never drop it within one step;
	// the caller lowers it after the last write.
	task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_DELIM_BYTES)
			cur_delim = value;
		else if (idx == REG_DELIM_LENGTH)
			cur_len = (value[3:0] > MAX_DELIM_BYTES) ? MAX_DELIM_BYTES : int'(value[3:0]);
	endtask

	// Send up to eight bytes from the lanes of a word, lowest lane first,
	// flagging the final one as the end of the source.
	task automatic send_lanes(input logic [63:0] lanes, input int n_bytes);
		for (int k = 0; k < n_bytes; k++)
			offer_byte(lanes[8*k +: 8], k == n_bytes - 1);
	endtask

	// Build a source out of whole delimiters and filler. Filler is mostly
	// taken from delimiter lanes so partial matches are common; a delimiter
	// cut short by the source length makes a broken match at the tail.
	task automatic send_source(input int n_bytes, input bit finish, input int dense_pct);
		logic [7:0] bytes_q[$];
		int         lane;
		while (bytes_q.size() < n_bytes) begin
			if (cur_len > 0 && $urandom_range(0, 99) < dense_pct) begin
				for (int k = 0; k < cur_len; k++)
					bytes_q.push_back(cur_delim[8*k +: 8]);
			end else if ($urandom_range(0, 2) == 0) begin
				bytes_q.push_back(8'($urandom));
			end else begin
				lane = (cur_len > 0) ? $urandom_range(0, cur_len - 1) : 0;
				bytes_q.push_back(cur_delim[8*lane +: 8]);
			end
		end
		while (bytes_q.size() > n_bytes)
			void'(bytes_q.pop_back());
		foreach (bytes_q[k])
			offer_byte(bytes_q[k], finish && (k == n_bytes - 1));
	endtask

	initial begin : source_driver
		int          rand_base;
		int          dense;
		logic [63:0] fill;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setting (single zero byte delimiter): a piece, an empty piece
		// between adjacent delimiters, and a trailing piece on the final byte.
		send_lanes(64'h42_00_00_41, 4);
		// delimiter on the final byte: the cut piece itself is marked last
		send_lanes(64'h00, 1);

		// two-byte delimiter with a limit of two: the third match is dropped
		// and the final byte gives a bare end marker
		pause_until_drained();
		write_reg(REG_DELIM_BYTES, 64'hCDAB);
		write_reg(REG_DELIM_LENGTH, 64'd2);
		write_reg(REG_MAX_PIECES, 64'd2);
		cfg_valid <= 1'b0;
		send_lanes(64'h11_CDAB_CDAB_CDAB, 7);

		// no split: the whole source is one piece
		pause_until_drained();
		write_reg(REG_DELIM_LENGTH, 64'd0);
		cfg_valid <= 1'b0;
		send_lanes(64'h03_02_01, 3);

		// zero limit: only the end marker, even on a matching final byte
		pause_until_drained();
		write_reg(REG_DELIM_BYTES, 64'd0);
		write_reg(REG_DELIM_LENGTH, 64'd1);
		write_reg(REG_MAX_PIECES, 64'd0);
		cfg_valid <= 1'b0;
		send_lanes(64'h00_00, 2);

		// length above eight acts as eight; full-width match on the last byte
		pause_until_drained();
		write_reg(REG_DELIM_BYTES, 64'hFF00_FF80_7F01_00FF);
		write_reg(REG_DELIM_LENGTH, 64'hFFFF_FFFF_FFFF_FFF9);
		write_reg(REG_MAX_PIECES, {33'd0, PIECES_RESET});
		cfg_valid <= 1'b0;
		send_lanes(64'hFF00_FF80_7F01_00FF, 8);

		// Back-pressure: the sink holds off while a dense burst streams in
		// with no gaps, so the result queue fills and full is raised.
		pause_until_drained();
		write_reg(REG_DELIM_BYTES, {$urandom, $urandom});
		write_reg(REG_DELIM_LENGTH, 64'd1);
		cfg_valid <= 1'b0;
		gaps_off = 1'b1;
		stall_request = 1'b1;
		send_source(40, 1'b1, 80);

		// Random phases: reconfigure while drained (sometimes mid-source),
		// then stream several sources of random content and density.
		rand_base = items_sent;
		while (items_sent - rand_base < ITEM_TARGET) begin
			pause_until_drained();
			if ($urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 4))
					0: fill = 64'd0;
					1: fill = '1;
					// one repeated byte: overlapping match candidates
					2: fill = {8{8'($urandom)}};
					default: fill = {$urandom, $urandom};
				endcase
				write_reg(REG_DELIM_BYTES, fill);
			end
			if ($urandom_range(0, 2) == 0) begin
				fill = {$urandom, $urandom};
				case ($urandom_range(0, 5))
					0: fill[3:0] = 4'd0;
					1: fill[3:0] = 4'd8;
					2: fill[3:0] = 4'($urandom_range(9, 15));
					default: fill[3:0] = 4'($urandom_range(1, 4));
				endcase
				write_reg(REG_DELIM_LENGTH, fill);
			end
			if ($urandom_range(0, 2) == 0) begin
				fill = {$urandom, $urandom};
				case ($urandom_range(0, 5))
					0: fill[30:0] = '0;
					1: fill[30:0] = PIECES_RESET;
					2: ;
					default: fill[30:0] = 31'($urandom_range(1, 4));
				endcase
				write_reg(REG_MAX_PIECES, fill);
			end
			if ($urandom_range(0, 15) == 0)
				write_reg(REG_UNUSED, {$urandom, $urandom});
			cfg_valid <= 1'b0;

			gaps_off = ($urandom_range(0, 4) == 0);
			// zero density places no whole delimiters, only filler bytes
			dense = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 60);
			repeat ($urandom_range(1, 4))
				send_source(($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
					: $urandom_range(1, 16), 1'b1, dense);
			// leave a source open so the next settings land mid-source
			if ($urandom_range(0, 3) == 0)
				send_source($urandom_range(1, 6), 1'b0, dense);
		end

		pause_until_drained();
		if (mismatches == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
